// ===== hdl/assert_macros.svh =====
// Assertion macros for the hash map RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition that must hold at every clock edge out of reset.
`define RCHM_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("rchm assertion failed");
// Same-cycle implication.
`define RCHM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rchm assertion failed");
`else
`define RCHM_ASSERT(lbl, cond)
`define RCHM_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// ===== hdl/rchm_pkg.sv =====
// Package: types, codes and constants of the resizing chained hash map.
`timescale 1ns / 1ps
package rchm_pkg;

  // Default geometry
  localparam int unsigned MIN_TABLE_BITS_DEF = 4;
  localparam int unsigned MAX_TABLE_BITS_DEF = 8;
  localparam int unsigned BUCKET_SLOTS_DEF   = 4;

  // Field widths
  localparam int CMD_W  = 3;
  localparam int KEY_W  = 32;
  localparam int VAL_W  = 32;
  localparam int HASH_W = 32;
  localparam int STAT_W = 2;
  localparam int ENT_W  = 11;
  localparam int SLOT_W = KEY_W + VAL_W;

  // Stream packing
  localparam int IN_W  = 72;
  localparam int OUT_W = 48;
  localparam int IN_KEY_LSB = CMD_W;
  localparam int IN_VAL_LSB = CMD_W + KEY_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_SEARCH  = 3'd0,
    CMD_INSERT  = 3'd1,
    CMD_REMOVE  = 3'd2,
    CMD_REPLACE = 3'd3,
    CMD_CLEAR   = 3'd4
  } cmd_code_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_NOTFOUND = 2'd1,
    STAT_EXISTS   = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DEC, S_ADD, S_FRD, S_PCHK, S_PCMP, S_HIT, S_MISS,
    S_SHCHK, S_SHWR, S_RCHK, S_RB, S_RBF, S_RI, S_RMUL, S_RADD,
    S_RDF, S_RDW, S_DONE, S_INIT, S_CZ, S_RZ
  } state_t;

  typedef enum logic [1:0] {FRD_PROBE, FRD_WALK, FRD_DEST} frd_sel_t;
  typedef enum logic [1:0] {SRD_PROBE, SRD_NEXT, SRD_WALK} srd_sel_t;
  typedef enum logic [1:0] {SWR_INS, SWR_REP, SWR_SHIFT, SWR_WALK} swr_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    logic     add_en;
    logic     walk;
    logic     frd_en;
    frd_sel_t frd_sel;
    logic     idx_clr;
    logic     idx_inc;
    logic     srd_en;
    srd_sel_t srd_sel;
    logic     swr_en;
    swr_sel_t swr_sel;
    logic     fwr_en;
    logic     fwr_dest;
    logic     fwr_dec;
    logic     fwr_zero;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     stat_en;
    status_t  stat;
    logic     vout_en;
    logic     clear_all;
    logic     rz_start;
    logic     rz_commit;
    logic     wb_clr;
    logic     wb_inc;
    logic     wfill_ld;
    logic     wi_inc;
    logic     out_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             hit;
    logic             idx_lt_fill;
    logic             idx_next_lt_fill;
    logic             bkt_full;
    logic             rsz_go;
    logic             walk_done;
    logic             zdest_done;
    logic             wi_lt_wfill;
    logic             out_free;
  } dp_stat_t;

endpackage

// ===== hdl/resizing_chained_hash_map_core.sv =====
// Top level of the resizing chained hash map: controller and datapath.
//
//  channel  direction  handshake              payload
//  in_      slave      in_tvalid/in_tready    in_tdata: command, key, value_in
//  out_     master     out_tvalid/out_tready  out_tdata: status, value_out, entries
//  cfg_     slave      cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One request at a time. A request probes the slots of its bucket in turn; a remove
// then shifts the later slots of the bucket down by one.
// After reset and on a clear, a pass over 2^MIN_TABLE_BITS buckets (16) zeroes the
// fill counts; in_tready stays low during the pass after reset. A resize first
// zeroes the new fill bank bucket by bucket, then rehashes the entries of each old
// bucket; a full new bucket abandons the resize. A stalled result sits in the
// output register while the next request is already taken.
`timescale 1ns / 1ps
module resizing_chained_hash_map_core #(
  parameter int unsigned MIN_TABLE_BITS = rchm_pkg::MIN_TABLE_BITS_DEF,
  parameter int unsigned MAX_TABLE_BITS = rchm_pkg::MAX_TABLE_BITS_DEF,
  parameter int unsigned BUCKET_SLOTS   = rchm_pkg::BUCKET_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // command[2:0], key[34:3], value_in[66:35], zero pad
  input  logic [rchm_pkg::IN_W-1:0]   in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // status[1:0], value_out[33:2], entries[44:34], zero pad
  output logic [rchm_pkg::OUT_W-1:0]  out_tdata,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [rchm_pkg::HASH_W-1:0] cfg_data
);
  import rchm_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t st;

  // Configuration is always taken
  assign cfg_ready = 1'b1;

  rchm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  rchm_dpath #(
    .MIN_TB (MIN_TABLE_BITS),
    .MAX_TB (MAX_TABLE_BITS),
    .SLOTS  (BUCKET_SLOTS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== hdl/rchm_ctrl.sv =====
// Controller state machine of the hash map: sequences probe, update and resize walk.
`timescale 1ns / 1ps
module rchm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  rchm_pkg::dp_stat_t  st,
  output rchm_pkg::dp_cmd_t   cmd
);
  import rchm_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_INIT;
    else        state_r <= state_nxt;
  end

  assign in_tready = (state_r == S_IDLE);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: if (st.walk_done) state_nxt = S_IDLE;
      S_IDLE: if (in_tvalid) state_nxt = S_DEC;
      S_DEC: begin
        if (st.cmd <= CMD_REPLACE)     state_nxt = S_ADD;
        else if (st.cmd == CMD_CLEAR)  state_nxt = S_CZ;
        else                           state_nxt = S_DONE;
      end
      S_CZ:   if (st.walk_done) state_nxt = S_DONE;
      S_ADD:  state_nxt = S_FRD;
      S_FRD:  state_nxt = S_PCHK;
      S_PCHK: state_nxt = st.idx_lt_fill ? S_PCMP : S_MISS;
      S_PCMP: state_nxt = st.hit ? S_HIT : S_PCHK;
      S_HIT:  state_nxt = (st.cmd == CMD_REMOVE) ? S_SHCHK : S_DONE;
      S_MISS: begin
        if (st.cmd == CMD_INSERT && !st.bkt_full) state_nxt = S_RCHK;
        else                                      state_nxt = S_DONE;
      end
      S_SHCHK: state_nxt = st.idx_next_lt_fill ? S_SHWR : S_RCHK;
      S_SHWR:  state_nxt = S_SHCHK;
      S_RCHK:  state_nxt = st.rsz_go ? S_RZ : S_DONE;
      S_RZ:    if (st.zdest_done) state_nxt = S_RB;
      S_RB:    state_nxt = st.walk_done ? S_DONE : S_RBF;
      S_RBF:   state_nxt = S_RI;
      S_RI:    state_nxt = st.wi_lt_wfill ? S_RMUL : S_RB;
      S_RMUL:  state_nxt = S_RADD;
      S_RADD:  state_nxt = S_RDF;
      S_RDF:   state_nxt = S_RDW;
      S_RDW:   state_nxt = st.bkt_full ? S_DONE : S_RI;
      S_DONE:  if (st.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_INIT, S_CZ: begin
        // zero the fill counts of the active bank
        if (!st.walk_done) begin
          cmd.fwr_en   = 1'b1;
          cmd.fwr_zero = 1'b1;
          cmd.wb_inc   = 1'b1;
        end
      end
      S_IDLE: cmd.load_in = in_tvalid;
      S_DEC: begin
        if (st.cmd <= CMD_REPLACE) begin
          cmd.mul_en = 1'b1;
        end else if (st.cmd == CMD_CLEAR) begin
          cmd.clear_all = 1'b1;
        end else begin
          cmd.stat_en = 1'b1;
          cmd.stat    = STAT_NOTFOUND;
        end
      end
      S_ADD: cmd.add_en = 1'b1;
      S_FRD: begin
        cmd.frd_en  = 1'b1;
        cmd.frd_sel = FRD_PROBE;
        cmd.idx_clr = 1'b1;
      end
      S_PCHK: begin
        cmd.srd_en  = st.idx_lt_fill;
        cmd.srd_sel = SRD_PROBE;
      end
      S_PCMP: cmd.idx_inc = !st.hit;
      S_HIT: begin
        priority case (st.cmd)
          CMD_INSERT: begin
            cmd.stat_en = 1'b1;
            cmd.stat    = STAT_EXISTS;
          end
          CMD_REPLACE: begin
            cmd.vout_en = 1'b1;
            cmd.swr_en  = 1'b1;
            cmd.swr_sel = SWR_REP;
          end
          default: cmd.vout_en = 1'b1;
        endcase
      end
      S_MISS: begin
        if (st.cmd == CMD_INSERT) begin
          if (st.bkt_full) begin
            cmd.stat_en = 1'b1;
            cmd.stat    = STAT_FULL;
          end else begin
            cmd.swr_en  = 1'b1;
            cmd.swr_sel = SWR_INS;
            cmd.fwr_en  = 1'b1;
            cmd.cnt_inc = 1'b1;
          end
        end else begin
          cmd.stat_en = 1'b1;
          cmd.stat    = STAT_NOTFOUND;
        end
      end
      S_SHCHK: begin
        if (st.idx_next_lt_fill) begin
          cmd.srd_en  = 1'b1;
          cmd.srd_sel = SRD_NEXT;
          cmd.idx_inc = 1'b1;
        end else begin
          cmd.fwr_en  = 1'b1;
          cmd.fwr_dec = 1'b1;
          cmd.cnt_dec = 1'b1;
        end
      end
      S_SHWR: begin
        cmd.swr_en  = 1'b1;
        cmd.swr_sel = SWR_SHIFT;
      end
      S_RCHK: cmd.rz_start = st.rsz_go;
      S_RZ: begin
        // zero the fill counts of the new bank, then restart the bucket counter
        if (st.zdest_done) begin
          cmd.wb_clr = 1'b1;
        end else begin
          cmd.fwr_en   = 1'b1;
          cmd.fwr_zero = 1'b1;
          cmd.fwr_dest = 1'b1;
          cmd.wb_inc   = 1'b1;
        end
      end
      S_RB: begin
        if (st.walk_done) begin
          cmd.rz_commit = 1'b1;
        end else begin
          cmd.frd_en  = 1'b1;
          cmd.frd_sel = FRD_WALK;
        end
      end
      S_RBF: cmd.wfill_ld = 1'b1;
      S_RI: begin
        if (st.wi_lt_wfill) begin
          cmd.srd_en  = 1'b1;
          cmd.srd_sel = SRD_WALK;
        end else begin
          cmd.wb_inc = 1'b1;
        end
      end
      S_RMUL: begin
        cmd.mul_en = 1'b1;
        cmd.walk   = 1'b1;
      end
      S_RADD: begin
        cmd.add_en = 1'b1;
        cmd.walk   = 1'b1;
      end
      S_RDF: begin
        cmd.frd_en  = 1'b1;
        cmd.frd_sel = FRD_DEST;
      end
      S_RDW: begin
        if (!st.bkt_full) begin
          cmd.swr_en   = 1'b1;
          cmd.swr_sel  = SWR_WALK;
          cmd.fwr_en   = 1'b1;
          cmd.fwr_dest = 1'b1;
          cmd.wi_inc   = 1'b1;
        end
      end
      S_DONE: cmd.out_load = st.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== hdl/rchm_dpath.sv =====
// Datapath of the hash map: hash unit, slot and fill memories, counters, result registers.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rchm_dpath #(
  parameter int unsigned MIN_TB = rchm_pkg::MIN_TABLE_BITS_DEF,
  parameter int unsigned MAX_TB = rchm_pkg::MAX_TABLE_BITS_DEF,
  parameter int unsigned SLOTS  = rchm_pkg::BUCKET_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rchm_pkg::dp_cmd_t           cmd,
  output rchm_pkg::dp_stat_t          st,
  input  logic [rchm_pkg::IN_W-1:0]   in_tdata,
  input  logic                        cfg_valid,
  input  logic                        cfg_index,
  input  logic [rchm_pkg::HASH_W-1:0] cfg_data,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [rchm_pkg::OUT_W-1:0]  out_tdata
);
  import rchm_pkg::*;

  localparam int NB     = 1 << MAX_TB;
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FILL_W = $clog2(SLOTS + 1);
  localparam int CAP    = NB * SLOTS;
  localparam int CNT_W  = $clog2(CAP + 1);
  localparam int TB_W   = $clog2(MAX_TB + 1);
  localparam int WB_W   = MAX_TB + 1;
  localparam int FA_W   = MAX_TB + 1;
  localparam int SA_W   = MAX_TB + 1 + IDX_W;
  localparam int LOAD_W = CNT_W + 2;

  // Configuration registers
  logic [HASH_W-1:0] hash_mult_r, hash_add_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_mult_r <= HASH_W'(1);
      hash_add_r  <= '0;
    end else if (cfg_valid) begin
      if (cfg_index) hash_add_r  <= cfg_data;
      else           hash_mult_r <= cfg_data;
    end
  end

  // Request registers
  logic [CMD_W-1:0] cmd_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] vin_r;
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r <= in_tdata[CMD_W-1:0];
      key_r <= in_tdata[IN_KEY_LSB +: KEY_W];
      vin_r <= in_tdata[IN_VAL_LSB +: VAL_W];
    end
  end

  // Table state
  logic [TB_W-1:0]  tb_r, nb_r;
  logic [CNT_W-1:0] cnt_r;
  logic             bank_r;
  logic [MAX_TB-1:0] hb_r;
  logic [FILL_W-1:0] fill_q, idx_r, wi_r, wfill_r;
  logic [WB_W-1:0]   wb_r;
  logic [SLOT_W-1:0] slot_q;

  // Hash unit: multiply, then add and take the top bits
  logic [HASH_W-1:0]   prod_r, mul_src, hsum, hshift;
  logic [2*HASH_W-1:0] prod_full;
  logic [TB_W-1:0]     hbits;
  assign mul_src   = cmd.walk ? slot_q[SLOT_W-1:VAL_W] : key_r;
  assign prod_full = {{HASH_W{1'b0}}, hash_mult_r} * {{HASH_W{1'b0}}, mul_src};
  assign hbits     = cmd.walk ? nb_r : tb_r;
  assign hsum      = prod_r + hash_add_r;
  assign hshift    = hsum >> (6'(HASH_W) - 6'(hbits));

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod_r <= prod_full[HASH_W-1:0];
    if (cmd.add_en) hb_r   <= hshift[MAX_TB-1:0];
  end

  // Load check
  logic [LOAD_W-1:0] load, size1, size3;
  logic shrink_ok, grow_ok;
  assign load      = {cnt_r, 2'b00};
  assign size1     = LOAD_W'(1) << tb_r;
  assign size3     = size1 + (size1 << 1);
  assign shrink_ok = (load < size1) && (tb_r > TB_W'(MIN_TB));
  assign grow_ok   = (load > size3) && (tb_r < TB_W'(MAX_TB));

  // Control registers of the table and the walk
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tb_r   <= TB_W'(MIN_TB);
      nb_r   <= TB_W'(MIN_TB);
      cnt_r  <= '0;
      bank_r <= 1'b0;
      idx_r  <= '0;
      wi_r   <= '0;
      wb_r   <= '0;
    end else begin
      if (cmd.clear_all) begin
        tb_r  <= TB_W'(MIN_TB);
        cnt_r <= '0;
        wb_r  <= '0;
      end
      if (cmd.cnt_inc) cnt_r <= cnt_r + 1'b1;
      if (cmd.cnt_dec) cnt_r <= cnt_r - 1'b1;
      if (cmd.idx_clr) idx_r <= '0;
      if (cmd.idx_inc) idx_r <= idx_r + 1'b1;
      if (cmd.rz_start) begin
        nb_r <= grow_ok ? TB_W'(tb_r + 1'b1) : TB_W'(tb_r - 1'b1);
        wb_r <= '0;
      end
      if (cmd.wb_clr)   wb_r <= '0;
      if (cmd.wb_inc)   wb_r <= wb_r + 1'b1;
      if (cmd.wfill_ld) wi_r <= '0;
      if (cmd.wi_inc)   wi_r <= wi_r + 1'b1;
      if (cmd.rz_commit) begin
        tb_r   <= nb_r;
        bank_r <= ~bank_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wfill_ld) wfill_r <= fill_q;
  end

  // Fill memory, two banks; a bank is zeroed entry by entry before it is used
  logic [FILL_W-1:0] fmem [2**FA_W];
  logic [FA_W-1:0]   fra, fwa;
  logic [FILL_W-1:0] fill_wd;
  logic              fw_bank;
  logic [MAX_TB-1:0] fw_row;

  always_comb begin
    unique case (cmd.frd_sel)
      FRD_WALK: fra = {bank_r, wb_r[MAX_TB-1:0]};
      FRD_DEST: fra = {~bank_r, hb_r};
      default:  fra = {bank_r, hb_r};
    endcase
  end
  assign fw_bank = cmd.fwr_dest ? ~bank_r : bank_r;
  assign fw_row  = cmd.fwr_zero ? wb_r[MAX_TB-1:0] : hb_r;
  assign fwa     = {fw_bank, fw_row};
  assign fill_wd = cmd.fwr_zero ? FILL_W'(0) :
                   cmd.fwr_dec  ? FILL_W'(fill_q - 1'b1) : FILL_W'(fill_q + 1'b1);

  always_ff @(posedge clk) begin
    if (cmd.fwr_en) fmem[fwa] <= fill_wd;
    if (cmd.frd_en) fill_q <= fmem[fra];
  end

  // Slot memory, two banks
  logic [SLOT_W-1:0] smem [2**SA_W];
  logic [SA_W-1:0]   sra, swa;
  logic [SLOT_W-1:0] swd;
  logic [FILL_W-1:0] idx_p1, idx_m1;
  assign idx_p1 = FILL_W'(idx_r + 1'b1);
  assign idx_m1 = FILL_W'(idx_r - 1'b1);

  always_comb begin
    unique case (cmd.srd_sel)
      SRD_NEXT: sra = {bank_r, hb_r, idx_p1[IDX_W-1:0]};
      SRD_WALK: sra = {bank_r, wb_r[MAX_TB-1:0], wi_r[IDX_W-1:0]};
      default:  sra = {bank_r, hb_r, idx_r[IDX_W-1:0]};
    endcase
  end

  always_comb begin
    unique case (cmd.swr_sel)
      SWR_INS: begin
        swa = {bank_r, hb_r, fill_q[IDX_W-1:0]};
        swd = {key_r, vin_r};
      end
      SWR_REP: begin
        swa = {bank_r, hb_r, idx_r[IDX_W-1:0]};
        swd = {key_r, vin_r};
      end
      SWR_SHIFT: begin
        swa = {bank_r, hb_r, idx_m1[IDX_W-1:0]};
        swd = slot_q;
      end
      default: begin
        swa = {~bank_r, hb_r, fill_q[IDX_W-1:0]};
        swd = slot_q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.swr_en) smem[swa] <= swd;
    if (cmd.srd_en) slot_q <= smem[sra];
  end

  // Result of the current request
  logic [STAT_W-1:0] status_r;
  logic [VAL_W-1:0]  vout_r;
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      status_r <= STAT_OK;
      vout_r   <= '0;
    end else begin
      if (cmd.stat_en) status_r <= cmd.stat;
      if (cmd.vout_en) vout_r   <= slot_q[VAL_W-1:0];
    end
  end

  // Output register
  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [VAL_W-1:0]  out_vout_r;
  logic [ENT_W-1:0]  out_ent_r;
  always_ff @(posedge clk) begin
    if (!rst_n)              out_valid_r <= 1'b0;
    else if (cmd.out_load)   out_valid_r <= 1'b1;
    else if (out_tready)     out_valid_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= status_r;
      out_vout_r   <= vout_r;
      out_ent_r    <= ENT_W'(cnt_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_W - ENT_W - VAL_W - STAT_W)'(0), out_ent_r, out_vout_r,
                       out_status_r};

  // Status to the controller
  assign st.cmd              = cmd_r;
  assign st.hit              = (slot_q[SLOT_W-1:VAL_W] == key_r);
  assign st.idx_lt_fill      = (idx_r < fill_q);
  assign st.idx_next_lt_fill = (({1'b0, idx_r} + 1'b1) < {1'b0, fill_q});
  assign st.bkt_full         = (fill_q >= FILL_W'(SLOTS));
  assign st.rsz_go           = shrink_ok || grow_ok;
  assign st.walk_done        = (wb_r == (WB_W'(1) << tb_r));
  assign st.zdest_done       = (wb_r == (WB_W'(1) << nb_r));
  assign st.wi_lt_wfill      = (wi_r < wfill_r);
  assign st.out_free         = !out_valid_r || out_tready;

  // Checks
  `RCHM_ASSERT(a_tb_range, (tb_r >= TB_W'(MIN_TB)) && (tb_r <= TB_W'(MAX_TB)))
  `RCHM_ASSERT_IMP(a_fill_cap, cmd.fwr_en, fill_wd <= FILL_W'(SLOTS))
  `RCHM_ASSERT_IMP(a_bank_commit, !$stable(bank_r), !$stable(tb_r))
  `RCHM_ASSERT(a_cnt_cap, cnt_r <= CNT_W'(CAP))

endmodule

// ===== tb/hash_map_checker.sv =====
// Request/reply checker for the hash map core: predicts every reply and compares it.
`timescale 1ns / 1ps
module hash_map_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [rchm_pkg::IN_W-1:0]   in_tdata,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [rchm_pkg::OUT_W-1:0]  out_tdata,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [rchm_pkg::HASH_W-1:0] cfg_data,
  output int                          errors,
  output int                          pending
);
  import rchm_pkg::*;

  localparam int MIN_BITS = MIN_TABLE_BITS_DEF;
  localparam int MAX_BITS = MAX_TABLE_BITS_DEF;
  localparam int SLOTS    = BUCKET_SLOTS_DEF;
  localparam int NBKT     = 1 << MAX_BITS;

  typedef struct packed {
    status_t          status;
    logic [VAL_W-1:0] value;
    logic [ENT_W-1:0] entries;
  } reply_t;

  reply_t expected_replies[$];

  // Shadow of the map
  logic [HASH_W-1:0] mult, add;
  logic [KEY_W-1:0]  slot_key[NBKT*SLOTS];
  logic [VAL_W-1:0]  slot_val[NBKT*SLOTS];
  int                bkt_fill[NBKT];
  logic [KEY_W-1:0]  tmp_key[NBKT*SLOTS];
  logic [VAL_W-1:0]  tmp_val[NBKT*SLOTS];
  int                tmp_fill[NBKT];
  int                bits;
  int                total;

  function automatic int bucket_of(logic [KEY_W-1:0] key, int nbits);
    logic [HASH_W-1:0] h;
    h = mult * key + add;
    return int'(h >> (HASH_W - nbits)) & (NBKT - 1);
  endfunction

  // Load check after a change; an overflowing rehash is dropped
  task automatic check_load();
    int nbits, k;
    if (total * 4 < (1 << bits)) begin
      if (bits <= MIN_BITS) return;
      nbits = bits - 1;
    end else if (total * 4 > 3 * (1 << bits)) begin
      if (bits >= MAX_BITS) return;
      nbits = bits + 1;
    end else return;
    foreach (tmp_fill[b]) tmp_fill[b] = 0;
    for (int b = 0; b < (1 << bits); b++)
      for (int i = 0; i < bkt_fill[b]; i++) begin
        k = bucket_of(slot_key[b*SLOTS+i], nbits);
        if (tmp_fill[k] >= SLOTS) return;
        tmp_key[k*SLOTS+tmp_fill[k]] = slot_key[b*SLOTS+i];
        tmp_val[k*SLOTS+tmp_fill[k]] = slot_val[b*SLOTS+i];
        tmp_fill[k]++;
      end
    slot_key = tmp_key;
    slot_val = tmp_val;
    bkt_fill = tmp_fill;
    bits = nbits;
  endtask

  task automatic predict_map_op(logic [IN_W-1:0] req);
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
    reply_t r;
    int b, pos, base;
    cmd = req[CMD_W-1:0];
    key = req[IN_KEY_LSB +: KEY_W];
    val = req[IN_VAL_LSB +: VAL_W];
    r.status = STAT_OK;
    r.value = '0;
    b = bucket_of(key, bits);
    base = b * SLOTS;
    pos = -1;
    if (cmd <= CMD_REPLACE)
      for (int i = 0; i < bkt_fill[b]; i++)
        if (pos < 0 && slot_key[base+i] == key) pos = i;
    case (cmd)
      CMD_SEARCH: begin
        if (pos < 0) r.status = STAT_NOTFOUND;
        else r.value = slot_val[base+pos];
      end
      CMD_INSERT: begin
        if (pos >= 0) r.status = STAT_EXISTS;
        else if (bkt_fill[b] >= SLOTS) r.status = STAT_FULL;
        else begin
          slot_key[base+bkt_fill[b]] = key;
          slot_val[base+bkt_fill[b]] = val;
          bkt_fill[b]++;
          total++;
          check_load();
        end
      end
      CMD_REMOVE: begin
        if (pos < 0) r.status = STAT_NOTFOUND;
        else begin
          r.value = slot_val[base+pos];
          for (int i = pos; i + 1 < bkt_fill[b]; i++) begin
            slot_key[base+i] = slot_key[base+i+1];
            slot_val[base+i] = slot_val[base+i+1];
          end
          bkt_fill[b]--;
          total--;
          check_load();
        end
      end
      CMD_REPLACE: begin
        if (pos < 0) r.status = STAT_NOTFOUND;
        else begin
          r.value = slot_val[base+pos];
          slot_val[base+pos] = val;
        end
      end
      CMD_CLEAR: begin
        foreach (bkt_fill[i]) bkt_fill[i] = 0;
        total = 0;
        bits = MIN_BITS;
      end
      default: r.status = STAT_NOTFOUND;
    endcase
    r.entries = total[ENT_W-1:0];
    expected_replies.push_back(r);
  endtask

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("[%0t] reply %s mismatch: got %0h, expected %0h", $realtime, field, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    mult = 1;
    add = 0;
    bits = MIN_BITS;
    total = 0;
    foreach (bkt_fill[i]) bkt_fill[i] = 0;
  end

  assign pending = expected_replies.size();

  always @(posedge clk) begin
    reply_t got, want;
    if (rst_n) begin
      // replies first: a reply never belongs to a request taken in the same cycle
      if (out_tvalid && out_tready) begin
        got.status  = status_t'(out_tdata[STAT_W-1:0]);
        got.value   = out_tdata[STAT_W +: VAL_W];
        got.entries = out_tdata[STAT_W+VAL_W +: ENT_W];
        if (expected_replies.size() == 0) begin
          $display("[%0t] reply with no request outstanding", $realtime);
          errors++;
        end else begin
          want = expected_replies.pop_front();
          if (got.status != want.status) report_mismatch("status", got.status, want.status);
          if (got.value != want.value) report_mismatch("value", got.value, want.value);
          if (got.entries != want.entries)
            report_mismatch("entries", got.entries, want.entries);
        end
      end
      if (in_tvalid && in_tready) predict_map_op(in_tdata);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == 1'b0) mult = cfg_data;
        else add = cfg_data;
      end
    end
  end
endmodule

// ===== tb/resizing_chained_hash_map_core_tb.sv =====
// Testbench top for the hash map core: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module resizing_chained_hash_map_core_tb;
  import rchm_pkg::*;

  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 275;
  localparam int STALL_LIMIT = 60000;
  localparam int POOL        = 400;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [IN_W-1:0]     in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_W-1:0]    out_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_index = 1'b0;
  logic [HASH_W-1:0]   cfg_data = '0;
  int                  errors, pending;

  int                  tx_idle_pct, rx_idle_pct;
  bit                  hold_req = 1'b0;
  int                  hold_cnt = 0;
  int                  idle_cycles = 0;
  int                  sent = 0;
  int                  cfg_writes = 0;
  logic [KEY_W-1:0]    key_pool[POOL];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  resizing_chained_hash_map_core dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  hash_map_checker u_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .errors, .pending
  );

  // Reply side: random back-pressure, plus one long hold-off on demand
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Watchdog: too long with no handshake anywhere
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // One request; called at a rising edge, returns once taken and any gap ends
  task automatic send_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                              logic [VAL_W-1:0] val);
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, val, key, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic idx, logic [HASH_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  // Wait until every reply is back, then let the core settle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_request();
    int pick;
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    pick = $urandom_range(0, 99);
    if (pick < 45) cmd = CMD_INSERT;
    else if (pick < 65) cmd = CMD_SEARCH;
    else if (pick < 82) cmd = CMD_REMOVE;
    else if (pick < 95) cmd = CMD_REPLACE;
    else if (pick < 97) cmd = CMD_CLEAR;
    else cmd = CMD_W'($urandom_range(5, 7));
    key = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, POOL - 1)];
    send_request(cmd, key, $urandom);
  endtask

  initial begin
    logic [HASH_W-1:0] mults[PHASES], adds[PHASES];
    mults = '{32'h1, 32'hFFFF_FFFF, 32'h9E37_79B1, 32'h2, 32'h0, 32'h0};
    adds  = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h0, 32'h0};
    mults[4] = $urandom | 32'h1;
    adds[4]  = $urandom;
    mults[5] = $urandom;
    adds[5]  = $urandom;
    tx_idle_pct = 9;
    rx_idle_pct = 88;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, every command, full bucket, shift on remove, clear
    send_request(CMD_SEARCH, 32'h0, 32'h0);
    send_request(CMD_INSERT, 32'h0, 32'h0);
    send_request(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_INSERT, 32'h0, 32'h5555_5555);
    send_request(CMD_SEARCH, 32'hFFFF_FFFF, 32'h0);
    send_request(CMD_REPLACE, 32'hFFFF_FFFF, 32'h1234_5678);
    send_request(CMD_REPLACE, 32'h7, 32'hAAAA_AAAA);
    send_request(CMD_REMOVE, 32'h7, 32'h0);
    send_request(CMD_REMOVE, 32'h0, 32'h0);
    for (int c = 5; c <= 7; c++) send_request(CMD_W'(c), 32'h0, 32'hFFFF_FFFF);
    for (int k = 1; k <= 5; k++) send_request(CMD_INSERT, k, 32'h100 + k);
    send_request(CMD_INSERT, 32'h1, 32'h0);
    send_request(CMD_REMOVE, 32'h2, 32'h0);
    send_request(CMD_SEARCH, 32'h4, 32'h0);
    send_request(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_SEARCH, 32'h1, 32'h0);
    drain();

    // Random phases, each with its own hash settings; flow-control mix per phase pair
    for (int p = 0; p < PHASES; p++) begin
      write_reg(1'b0, mults[p]);
      write_reg(1'b1, adds[p]);
      if (p < 2) begin
        tx_idle_pct = 9;
        rx_idle_pct = 88;
      end else if (p < 4) begin
        tx_idle_pct = 88;
        rx_idle_pct = 9;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      // narrow key ranges crowd buckets; wide ones exercise growth
      foreach (key_pool[i])
        key_pool[i] = (p % 2 == 0) ? $urandom_range(0, 1023) << $urandom_range(0, 22)
                                   : $urandom;
      @(posedge clk);
      if (p == 4) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) random_request();
      drain();
    end

    $display("ran %0d requests through %0d hash settings (%0d register writes)",
             sent, PHASES, cfg_writes);
    $display("covered all commands, full buckets, resizes and a long reply stall");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/rchm_pkg.sv
hdl/rchm_ctrl.sv
hdl/rchm_dpath.sv
hdl/resizing_chained_hash_map_core.sv
tb/hash_map_checker.sv
tb/resizing_chained_hash_map_core_tb.sv
